@@ src/pdf_pkg.sv @@
// shared types, constants and the hash mix step of the prefetch duplicate filter
`timescale 1ns / 1ps
`default_nettype none

package pdf_pkg;

  localparam int ADDR_WIDTH = 64;
  localparam int KIND_WIDTH = 2;
  localparam int OUT_COUNT_WIDTH = 16;

  localparam int DEF_INDEX_BITS = 10;
  localparam int DEF_TAG_BITS = 6;
  localparam int DEF_LINE_OFFSET_BITS = 6;
  localparam int DEF_COUNT_WIDTH = 16;

  localparam int QUEUE_DEPTH = 2;

  localparam int MIX_STEPS = 8;
  localparam int STEP_BITS = $clog2(MIX_STEPS);

  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_L2_PF  = 2'd0,
    KIND_LLC_PF = 2'd1,
    KIND_DEMAND = 2'd2,
    KIND_EVICT  = 2'd3
  } kind_t;

  // one step of the shift/add/xor line mix, wrapping at 64 bits
  function automatic logic [ADDR_WIDTH-1:0] mix_step(input logic [ADDR_WIDTH-1:0] k,
                                                      input logic [STEP_BITS-1:0] step);
    logic [ADDR_WIDTH-1:0] res;
    case (step)
      3'd0:    res = k + (k << 12);
      3'd1:    res = k ^ (k >> 22);
      3'd2:    res = k + (k << 4);
      3'd3:    res = k ^ (k >> 9);
      3'd4:    res = k + (k << 10);
      3'd5:    res = k ^ (k >> 2);
      3'd6:    res = k + (k << 7);
      default: res = k ^ (k >> 12);
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

@@ src/pdf_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module pdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

@@ src/pdf_front.sv @@
// front end: takes an item and hashes its line number into index and tag
`timescale 1ns / 1ps
`default_nettype none

module pdf_front #(
  parameter int LINE_OFFSET_BITS = pdf_pkg::DEF_LINE_OFFSET_BITS,
  parameter int HASH_BITS = pdf_pkg::DEF_INDEX_BITS + pdf_pkg::DEF_TAG_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 take,
  input  wire logic [pdf_pkg::KIND_WIDTH-1:0]       in_kind,
  input  wire logic [pdf_pkg::ADDR_WIDTH-1:0]       in_address,
  output logic                                      busy,
  input  wire logic                                 q_full,
  output logic                                      push,
  output logic [pdf_pkg::KIND_WIDTH+HASH_BITS-1:0]  push_data
);

  localparam int SB = pdf_pkg::STEP_BITS;
  localparam logic [SB-1:0] STEP_LAST = SB'(pdf_pkg::MIX_STEPS - 1);

  typedef enum logic [1:0] {S_IDLE, S_MIX, S_MUL, S_PUSH} state_t;

  state_t                          state_r;
  logic [SB-1:0]                   step_r;
  pdf_pkg::kind_t                  kind_r;
  logic [pdf_pkg::ADDR_WIDTH-1:0]  k_r;
  logic [HASH_BITS-1:0]            hash_r;
  logic [31:0]                     prod;

  // only the low 32 bits of the hash are ever used, so one 32x32 low half will do
  assign prod = k_r[34:3] * pdf_pkg::HASH_MULT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (take) begin
            kind_r  <= pdf_pkg::kind_t'(in_kind);
            k_r     <= in_address >> LINE_OFFSET_BITS;
            step_r  <= '0;
            state_r <= S_MIX;
          end
        end
        S_MIX: begin
          k_r    <= pdf_pkg::mix_step(k_r, step_r);
          step_r <= step_r + SB'(1);
          if (step_r == STEP_LAST) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          hash_r  <= prod[HASH_BITS-1:0];
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (!q_full) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign push      = (state_r == S_PUSH) && !q_full;
  assign push_data = {kind_r, hash_r};

endmodule

`default_nettype wire

@@ src/pdf_queue.sv @@
// short fifo between the hash front end and the table back end
`timescale 1ns / 1ps
`default_nettype none

module pdf_queue #(
  parameter int WIDTH = 18,
  parameter int DEPTH = pdf_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r;
  logic [PW-1:0]    rptr_r;
  logic [CW-1:0]    cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        mem_r[wptr_r] <= push_data;
        wptr_r        <= (wptr_r == PTR_LAST) ? '0 : wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == PTR_LAST) ? '0 : rptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  assign pop_data = mem_r[rptr_r];
  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CNT_FULL);

endmodule

`default_nettype wire

@@ src/pdf_back.sv @@
// back end: clears the entry table after reset, then reads one entry per item and writes it back if the item changes it
`timescale 1ns / 1ps
`default_nettype none

module pdf_back #(
  parameter int INDEX_BITS = pdf_pkg::DEF_INDEX_BITS,
  parameter int TAG_BITS = pdf_pkg::DEF_TAG_BITS,
  parameter int COUNT_WIDTH = pdf_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst_n,
  input  wire logic                                           q_empty,
  input  wire logic [pdf_pkg::KIND_WIDTH+INDEX_BITS+TAG_BITS-1:0] q_data,
  output logic                                                q_pop,
  output logic                                                clearing,
  output logic                                                out_valid,
  output logic                                                out_allow,
  output logic [pdf_pkg::OUT_COUNT_WIDTH-1:0]                 out_useful_prefetches
);

  localparam int HB = INDEX_BITS + TAG_BITS;
  localparam int EW = 2 + TAG_BITS;
  localparam int OW = pdf_pkg::OUT_COUNT_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_t;

  state_t                  state_r;
  logic [INDEX_BITS-1:0]   clr_r;
  pdf_pkg::kind_t          kind_r;
  logic [INDEX_BITS-1:0]   idx_r;
  logic [TAG_BITS-1:0]     tag_r;
  logic [COUNT_WIDTH-1:0]  count_r;
  logic [COUNT_WIDTH-1:0]  count_nxt;
  logic                    out_valid_r;
  logic                    out_allow_r;
  logic [OW-1:0]           out_count_r;

  logic [INDEX_BITS-1:0]   head_idx;
  logic [TAG_BITS-1:0]     head_tag;
  logic [EW-1:0]           rdata;
  logic                    e_valid;
  logic                    e_useful;
  logic [TAG_BITS-1:0]     e_tag;
  logic                    tag_hit;
  logic                    present;
  logic                    upd_we;
  logic [EW-1:0]           upd_data;
  logic                    allow;
  logic                    ram_we;
  logic [INDEX_BITS-1:0]   ram_waddr;
  logic [EW-1:0]           ram_wdata;
  logic [COUNT_WIDTH+OW-1:0] count_ext;

  assign head_idx = q_data[HB-1:TAG_BITS];
  assign head_tag = q_data[TAG_BITS-1:0];

  // entry layout: valid, useful, tag
  pdf_ram #(
    .WIDTH (EW),
    .DEPTH (2 ** INDEX_BITS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_idx),
    .rdata (rdata)
  );

  assign e_valid  = rdata[EW-1];
  assign e_useful = rdata[EW-2];
  assign e_tag    = rdata[TAG_BITS-1:0];
  assign tag_hit  = (e_tag == tag_r);
  assign present  = (e_valid || e_useful) && tag_hit;

  always_comb begin
    upd_we    = 1'b0;
    upd_data  = rdata;
    allow     = 1'b1;
    count_nxt = count_r;
    case (kind_r)
      pdf_pkg::KIND_L2_PF: begin
        if (present) begin
          allow = 1'b0;
        end else begin
          upd_we   = 1'b1;
          upd_data = {1'b1, 1'b0, tag_r};
        end
      end
      pdf_pkg::KIND_LLC_PF: begin
        if (present) begin
          allow = 1'b0;
        end
      end
      pdf_pkg::KIND_DEMAND: begin
        // a cleared entry has tag zero, so a demand can mark it useful without counting
        if (tag_hit && !e_useful) begin
          upd_we   = 1'b1;
          upd_data = {e_valid, 1'b1, e_tag};
          if (e_valid && count_r != COUNT_MAX) begin
            count_nxt = count_r + COUNT_WIDTH'(1);
          end
        end
      end
      pdf_pkg::KIND_EVICT: begin
        upd_we   = 1'b1;
        upd_data = '0;
        if (e_valid && !e_useful && count_r != '0) begin
          count_nxt = count_r - COUNT_WIDTH'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = upd_data;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      S_EXEC:  ram_we = upd_we;
      default: ;
    endcase
  end

  assign count_ext = {{OW{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + INDEX_BITS'(1);
          if (clr_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            kind_r  <= pdf_pkg::kind_t'(q_data[HB+pdf_pkg::KIND_WIDTH-1:HB]);
            idx_r   <= head_idx;
            tag_r   <= head_tag;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          count_r     <= count_nxt;
          out_valid_r <= 1'b1;
          out_allow_r <= allow;
          out_count_r <= count_ext[OW-1:0];
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign q_pop                 = (state_r == S_IDLE) && !q_empty;
  assign clearing              = (state_r == S_CLEAR);
  assign out_valid             = out_valid_r;
  assign out_allow             = out_allow_r;
  assign out_useful_prefetches = out_count_r;

endmodule

`default_nettype wire

@@ src/prefetch_duplicate_filter.sv @@
// top level of the prefetch duplicate filter
`timescale 1ns / 1ps
`default_nettype none

// Duplicate filter for prefetches: each item (kind, byte address) yields one result
// (allow, useful_prefetches) on out_valid, held for a single cycle; the receiver cannot
// stall, so results must be captured when out_valid is high. An item is taken when start
// is high and busy is low. The front end hashes the line number with a shared mix unit
// that performs one of eight steps per cycle, then a multiply and a hand-off to a
// two-entry queue; busy stays high until the item is pushed, which waits while the queue
// is full. The back end then reads and writes the entry table. After reset, busy stays
// high while the entry table is cleared one entry per cycle.
module prefetch_duplicate_filter #(
  parameter int INDEX_BITS = pdf_pkg::DEF_INDEX_BITS,
  parameter int TAG_BITS = pdf_pkg::DEF_TAG_BITS,
  parameter int LINE_OFFSET_BITS = pdf_pkg::DEF_LINE_OFFSET_BITS,
  parameter int COUNT_WIDTH = pdf_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [pdf_pkg::KIND_WIDTH-1:0]       in_kind,
  input  wire logic [pdf_pkg::ADDR_WIDTH-1:0]       in_address,
  output logic                                      out_valid,
  output logic                                      out_allow,
  output logic [pdf_pkg::OUT_COUNT_WIDTH-1:0]       out_useful_prefetches
);

  localparam int HASH_BITS = INDEX_BITS + TAG_BITS;
  localparam int QW = pdf_pkg::KIND_WIDTH + HASH_BITS;

  logic          front_busy;
  logic          clearing;
  logic          take;
  logic          q_push;
  logic [QW-1:0] q_push_data;
  logic          q_full;
  logic          q_pop;
  logic [QW-1:0] q_pop_data;
  logic          q_empty;

  assign busy = front_busy || clearing;
  assign take = start && !busy;

  pdf_front #(
    .LINE_OFFSET_BITS (LINE_OFFSET_BITS),
    .HASH_BITS        (HASH_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .in_kind    (in_kind),
    .in_address (in_address),
    .busy       (front_busy),
    .q_full     (q_full),
    .push       (q_push),
    .push_data  (q_push_data)
  );

  pdf_queue #(
    .WIDTH (QW),
    .DEPTH (pdf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  pdf_back #(
    .INDEX_BITS  (INDEX_BITS),
    .TAG_BITS    (TAG_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_empty               (q_empty),
    .q_data                (q_pop_data),
    .q_pop                 (q_pop),
    .clearing              (clearing),
    .out_valid             (out_valid),
    .out_allow             (out_allow),
    .out_useful_prefetches (out_useful_prefetches)
  );

endmodule

`default_nettype wire

@@ tb/sv/pdf_result_checker.sv @@
// checker for the prefetch duplicate filter: predicts each result and compares it
`timescale 1ns / 1ps

module pdf_result_checker
  import pdf_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic                       busy,
  input  wire logic [KIND_WIDTH-1:0]      in_kind,
  input  wire logic [ADDR_WIDTH-1:0]      in_address,
  input  wire logic                       out_valid,
  input  wire logic                       out_allow,
  input  wire logic [OUT_COUNT_WIDTH-1:0] out_useful_prefetches,
  output int                              failures,
  output int                              pending,
  output int                              checked,
  output int                              refused
);

  localparam int INDEX_BITS = DEF_INDEX_BITS;
  localparam int TAG_BITS = DEF_TAG_BITS;
  localparam int LINE_OFFSET_BITS = DEF_LINE_OFFSET_BITS;
  localparam int COUNT_WIDTH = DEF_COUNT_WIDTH;
  localparam int ENTRIES = 1 << INDEX_BITS;

  typedef struct packed {
    logic                       allow;
    logic [OUT_COUNT_WIDTH-1:0] useful;
  } filter_result_t;

  logic                   entry_valid [ENTRIES];
  logic                   entry_useful [ENTRIES];
  logic [TAG_BITS-1:0]    entry_tag [ENTRIES];
  logic [COUNT_WIDTH-1:0] useful_count;

  filter_result_t expected_results [$];
  int fail_count = 0;
  int checked_count = 0;
  int refused_count = 0;

  // shift/add/xor mix of the line number, then shift and multiply, all mod 2^64
  function automatic logic [ADDR_WIDTH-1:0] line_signature(input logic [ADDR_WIDTH-1:0] line);
    logic [ADDR_WIDTH-1:0] k;
    k = line;
    k = k + (k << 12);
    k = k ^ (k >> 22);
    k = k + (k << 4);
    k = k ^ (k >> 9);
    k = k + (k << 10);
    k = k ^ (k >> 2);
    k = k + (k << 7);
    k = k ^ (k >> 12);
    return (k >> 3) * 64'd2654435761;
  endfunction

  function automatic filter_result_t predict_filter_result(input kind_t kind,
                                                           input logic [ADDR_WIDTH-1:0] addr);
    logic [ADDR_WIDTH-1:0] sig;
    logic [INDEX_BITS-1:0] slot;
    logic [TAG_BITS-1:0]   tag;
    logic                  hit;
    filter_result_t        res;
    sig = line_signature(addr >> LINE_OFFSET_BITS);
    tag = sig[TAG_BITS-1:0];
    slot = sig[TAG_BITS +: INDEX_BITS];
    hit = (entry_valid[slot] || entry_useful[slot]) && entry_tag[slot] == tag;
    res.allow = 1'b1;
    case (kind)
      KIND_L2_PF: begin
        if (hit) begin
          res.allow = 1'b0;
        end else begin
          entry_valid[slot] = 1'b1;
          entry_useful[slot] = 1'b0;
          entry_tag[slot] = tag;
        end
      end
      KIND_LLC_PF: begin
        if (hit) res.allow = 1'b0;
      end
      KIND_DEMAND: begin
        // a cleared entry has tag zero, so a demand can mark it useful without counting
        if (entry_tag[slot] == tag && !entry_useful[slot]) begin
          entry_useful[slot] = 1'b1;
          if (entry_valid[slot] && useful_count != '1) useful_count = useful_count + 1'b1;
        end
      end
      default: begin
        if (entry_valid[slot] && !entry_useful[slot] && useful_count != '0)
          useful_count = useful_count - 1'b1;
        entry_valid[slot] = 1'b0;
        entry_useful[slot] = 1'b0;
        entry_tag[slot] = '0;
      end
    endcase
    res.useful = useful_count[OUT_COUNT_WIDTH-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    filter_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        entry_valid[i] = 1'b0;
        entry_useful[i] = 1'b0;
        entry_tag[i] = '0;
      end
      useful_count = '0;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding: allow %0d, useful_prefetches %0d",
                 out_allow, out_useful_prefetches);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          checked_count++;
          if (!want.allow) refused_count++;
          if (out_allow !== want.allow) begin
            $error("out_allow mismatch: expected %0d, actual %0d", want.allow, out_allow);
            fail_count++;
          end
          if (out_useful_prefetches !== want.useful) begin
            $error("out_useful_prefetches mismatch: expected %0d, actual %0d",
                   want.useful, out_useful_prefetches);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        expected_results.push_back(predict_filter_result(kind_t'(in_kind), in_address));
    end
    failures <= fail_count;
    pending <= expected_results.size();
    checked <= checked_count;
    refused <= refused_count;
  end

endmodule

@@ tb/sv/prefetch_duplicate_filter_tb.sv @@
// testbench top for the prefetch duplicate filter: stimulus, reset and verdict
`timescale 1ns / 1ps

module prefetch_duplicate_filter_tb;
  import pdf_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int POOL_SIZE = 48;
  localparam int DRAIN_LIMIT = 2000;
  localparam logic [ADDR_WIDTH-1:0] OFFSET_MASK = (64'd1 << DEF_LINE_OFFSET_BITS) - 1;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [KIND_WIDTH-1:0]      in_kind = KIND_L2_PF;
  logic [ADDR_WIDTH-1:0]      in_address = '0;
  logic                       out_valid;
  logic                       out_allow;
  logic [OUT_COUNT_WIDTH-1:0] out_useful_prefetches;

  int failures;
  int pending;
  int checked;
  int refused;

  int items_sent = 0;
  int directed_sent;
  int burst_left = 0;
  int drain_cycles = 0;
  int kind_sent [4] = '{0, 0, 0, 0};
  logic [ADDR_WIDTH-1:0] line_pool [POOL_SIZE];
  logic [ADDR_WIDTH-1:0] line;
  int pick;

  prefetch_duplicate_filter dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_kind               (in_kind),
    .in_address            (in_address),
    .out_valid             (out_valid),
    .out_allow             (out_allow),
    .out_useful_prefetches (out_useful_prefetches)
  );

  pdf_result_checker result_check (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_kind               (in_kind),
    .in_address            (in_address),
    .out_valid             (out_valid),
    .out_allow             (out_allow),
    .out_useful_prefetches (out_useful_prefetches),
    .failures              (failures),
    .pending               (pending),
    .checked               (checked),
    .refused               (refused)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", pending);
    $display("prefetch_duplicate_filter_tb: FAIL");
    $finish;
  end

  // sender works in bursts; a gap drops start for a random number of cycles
  task automatic send_item(input kind_t kind, input logic [ADDR_WIDTH-1:0] addr);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_address <= addr;
    do @(posedge clk); while (busy);
    burst_left--;
    items_sent++;
    kind_sent[kind]++;
  endtask

  // random byte within a line
  function automatic logic [ADDR_WIDTH-1:0] byte_in(input logic [ADDR_WIDTH-1:0] line_addr);
    return line_addr | (ADDR_WIDTH'($urandom) & OFFSET_MASK);
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // line zero hashes to tag zero, matching a cleared entry
    send_item(KIND_DEMAND, 64'h0);
    send_item(KIND_L2_PF, 64'h3f);
    send_item(KIND_LLC_PF, 64'h0);
    send_item(KIND_EVICT, 64'h0);
    send_item(KIND_L2_PF, 64'h0);
    // evict of an unused prefetch while the count is already zero
    send_item(KIND_EVICT, 64'h0);
    send_item(KIND_L2_PF, 64'hffff_ffff_ffff_ffff);
    send_item(KIND_L2_PF, 64'hffff_ffff_ffff_ffff);
    send_item(KIND_LLC_PF, 64'hffff_ffff_ffff_ffc0);
    send_item(KIND_LLC_PF, 64'h8000_0000_0000_0000);
    send_item(KIND_L2_PF, 64'h8000_0000_0000_0012);
    send_item(KIND_DEMAND, 64'hffff_ffff_ffff_ffff);
    send_item(KIND_DEMAND, 64'hffff_ffff_ffff_ffc1);
    send_item(KIND_DEMAND, 64'h8000_0000_0000_0000);
    send_item(KIND_EVICT, 64'hffff_ffff_ffff_ffff);
    send_item(KIND_L2_PF, 64'h5555_5555_5555_5555);
    send_item(KIND_EVICT, 64'h5555_5555_5555_5555);
    send_item(KIND_L2_PF, 64'haaaa_aaaa_aaaa_aaaa);
    send_item(KIND_DEMAND, 64'haaaa_aaaa_aaaa_aaaa);
    send_item(KIND_L2_PF, 64'haaaa_aaaa_aaaa_aaaa);
    send_item(KIND_EVICT, 64'h8000_0000_0000_0000);
    send_item(KIND_EVICT, 64'h1234_5678_9abc_def0);
    directed_sent = items_sent;

    for (int i = 0; i < POOL_SIZE; i++) line_pool[i] = {$urandom, $urandom} & ~OFFSET_MASK;

    while (items_sent - directed_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      line = line_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (pick < 70) begin
        // prefetch, maybe a duplicate, demand hits, then eviction
        send_item(KIND_L2_PF, byte_in(line));
        if ($urandom_range(0, 1) == 1)
          send_item(($urandom_range(0, 1) == 1) ? KIND_L2_PF : KIND_LLC_PF, byte_in(line));
        if ($urandom_range(0, 9) < 7) send_item(KIND_DEMAND, byte_in(line));
        if ($urandom_range(0, 9) < 3) send_item(KIND_DEMAND, byte_in(line));
        if ($urandom_range(0, 9) < 6) send_item(KIND_EVICT, byte_in(line));
      end else if (pick < 85) begin
        send_item(kind_t'($urandom_range(0, 3)), byte_in(line));
      end else begin
        send_item(kind_t'($urandom_range(0, 3)), {$urandom, $urandom});
      end
      if ($urandom_range(0, 49) == 0)
        line_pool[$urandom_range(0, POOL_SIZE - 1)] = {$urandom, $urandom} & ~OFFSET_MASK;
    end
    start <= 1'b0;

    do begin
      @(posedge clk);
      drain_cycles++;
    end while (pending != 0 && drain_cycles < DRAIN_LIMIT);
    repeat (20) @(posedge clk);

    $display("sent %0d items: %0d L2 prefetch, %0d LLC prefetch, %0d demand, %0d evict",
             items_sent, kind_sent[KIND_L2_PF], kind_sent[KIND_LLC_PF],
             kind_sent[KIND_DEMAND], kind_sent[KIND_EVICT]);
    $display("%0d results checked, %0d prefetches refused, %0d errors, %0d left outstanding",
             checked, refused, failures, pending);
    if (failures == 0 && pending == 0) begin
      $display("prefetch_duplicate_filter_tb: PASS");
    end else begin
      $display("prefetch_duplicate_filter_tb: FAIL");
    end
    $finish;
  end

endmodule
